// File: rtl/ddgr_pkg.sv
// ============================================================================
// ddgr_pkg: shared types and constants of the decimal digit glyph renderer
// Field widths, defaults, front state encoding and the 3x5 digit font.
// ============================================================================
package ddgr_pkg;

  localparam int VALUE_W      = 32;
  localparam int POS_W        = 12;
  localparam int FW_W         = 13;
  localparam int ADDR_OUT_W   = 24;
  localparam int GLYPH_W      = 15;
  localparam int DIGIT_W      = 4;
  // pos_y*frame_width + pos_x + 5*place stays below 2^25 for all inputs
  localparam int ROW_W        = 25;
  // a 32-bit number never has more than ten decimal digits
  localparam int VALUE_DIGITS = 10;
  localparam int CNT_W        = 4;

  localparam int DIGITS_DEF       = 15;
  localparam int ADDRESS_BITS_DEF = 24;
  localparam int GLYPH_STEP       = 5;

  localparam logic [FW_W-1:0]    FW_RESET    = 13'd640;
  // floor(n * RECIP_10 / 2^RECIP_SHIFT) == n / 10 for every 32-bit n
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ddgr_qctl_t;

  function automatic logic [GLYPH_W-1:0] ddgr_glyph(input logic [DIGIT_W-1:0] d);
    logic [GLYPH_W-1:0] g;
    unique case (d)
      4'd0:    g = 15'h7B6F;
      4'd1:    g = 15'h7493;
      4'd2:    g = 15'h73E7;
      4'd3:    g = 15'h79E7;
      4'd4:    g = 15'h49ED;
      4'd5:    g = 15'h79CF;
      4'd6:    g = 15'h7BCF;
      4'd7:    g = 15'h4927;
      4'd8:    g = 15'h7BEF;
      4'd9:    g = 15'h49EF;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/ddgr_if.sv
// ============================================================================
// ddgr_if: channel interfaces of the decimal digit glyph renderer
// Valid/ready channels for numbers in, digit results out and register writes.
// ============================================================================
interface ddgr_in_if;
  import ddgr_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;

  modport source (output valid, output value, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input value, input pos_x, input pos_y, output ready);
endinterface

interface ddgr_out_if;
  import ddgr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ADDR_OUT_W-1:0] base_address;
  logic [GLYPH_W-1:0]    glyph_mask;
  logic [DIGIT_W-1:0]    digit_value;
  logic                  last;

  modport source (output valid, output base_address, output glyph_mask,
                  output digit_value, output last, input ready);
  modport sink   (input valid, input base_address, input glyph_mask,
                  input digit_value, input last, output ready);
endinterface

interface ddgr_cfg_if;
  import ddgr_pkg::*;

  logic            valid;
  logic            ready;
  logic [FW_W-1:0] frame_width;

  modport source (output valid, output frame_width, input ready);
  modport sink   (input valid, input frame_width, output ready);
endinterface

// File: rtl/ddgr_front.sv
// ============================================================================
// ddgr_front: item intake and decimal split
// Takes a number, forms the row base address, peels off one decimal digit
// per cycle and pushes the finished item into the queue.
// ============================================================================
module ddgr_front #(
  parameter int DIGITS = ddgr_pkg::DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ddgr_in_if.sink                        in_ch,
  input  logic [ddgr_pkg::FW_W-1:0]      frame_width,
  input  ddgr_pkg::ddgr_qctl_t           qctl,
  output logic                           push,
  output logic [DIGITS-1:0][ddgr_pkg::DIGIT_W-1:0] push_digs,
  output logic [ddgr_pkg::ROW_W-1:0]     push_row
);
  import ddgr_pkg::*;

  localparam int IDX_W = $clog2(DIGITS);

  fe_state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]               cnt_r;
  logic [VALUE_W-1:0]             num_r;
  logic [DIGITS-1:0][DIGIT_W-1:0] digs_r;
  logic [ROW_W-1:0]               row_r;

  logic                           accept;
  logic                           last_div;
  logic [2*VALUE_W-1:0]           prod;
  logic [VALUE_W-1:0]             quot;
  logic [VALUE_W-1:0]             rem_full;

  // divide by ten through the reciprocal, remainder by shift-add
  assign prod     = {{VALUE_W{1'b0}}, num_r} * {{VALUE_W{1'b0}}, RECIP_10};
  assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
  assign rem_full = num_r - ((quot << 3) + (quot << 1));

  assign push         = (state_r == FE_PUSH) && !qctl.full;
  assign in_ch.ready  = (state_r == FE_IDLE) || push;
  assign accept       = in_ch.valid && in_ch.ready;
  assign last_div     = cnt_r == CNT_W'(VALUE_DIGITS - 1);
  assign push_digs    = digs_r;
  assign push_row     = row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == FE_DIV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      num_r  <= in_ch.value;
      digs_r <= '0;
      row_r  <= ROW_W'(in_ch.pos_y) * ROW_W'(frame_width) + ROW_W'(in_ch.pos_x);
    end else if (state_r == FE_DIV) begin
      num_r                 <= quot;
      digs_r[IDX_W'(cnt_r)] <= rem_full[DIGIT_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FE_IDLE: begin
        if (accept) state_nxt = FE_DIV;
      end
      FE_DIV: begin
        if (last_div) state_nxt = FE_PUSH;
      end
      FE_PUSH: begin
        if (push) state_nxt = accept ? FE_DIV : FE_IDLE;
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

endmodule

// File: rtl/ddgr_queue.sv
// ============================================================================
// ddgr_queue: two-entry item queue
// Decouples the digit split from result emission.
// ============================================================================
module ddgr_queue #(
  parameter int W = 85
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [W-1:0]         push_data,
  input  logic                 pop,
  output logic [W-1:0]         head_data,
  output ddgr_pkg::ddgr_qctl_t qctl
);
  import ddgr_pkg::*;

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;

  assign head_data  = mem_r[rd_ptr_r];
  assign qctl.full  = count_r == 2'd2;
  assign qctl.empty = count_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: rtl/ddgr_back.sv
// ============================================================================
// ddgr_back: digit result emission
// Walks the queue head most significant digit first, one result per cycle
// while out_ch accepts and the queue holds an item, into a registered output stage.
// ============================================================================
module ddgr_back #(
  parameter int DIGITS       = ddgr_pkg::DIGITS_DEF,
  parameter int ADDRESS_BITS = ddgr_pkg::ADDRESS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ddgr_pkg::ddgr_qctl_t           qctl,
  input  logic [DIGITS-1:0][ddgr_pkg::DIGIT_W-1:0] head_digs,
  input  logic [ddgr_pkg::ROW_W-1:0]     head_row,
  output logic                           pop,
  ddgr_out_if.source                     out_ch
);
  import ddgr_pkg::*;

  localparam int PLACE_W = $clog2(DIGITS);
  localparam int ACC_W   = $clog2(GLYPH_STEP * DIGITS);
  localparam logic [32:0] ADDR_MASK = (33'd1 << ADDRESS_BITS) - 33'd1;

  logic [PLACE_W-1:0]    place_r;
  logic [ACC_W-1:0]      acc_r;
  logic                  valid_r;
  logic [ADDR_OUT_W-1:0] addr_r;
  logic [GLYPH_W-1:0]    glyph_r;
  logic [DIGIT_W-1:0]    digit_r;
  logic                  last_r;

  logic                  advance;
  logic                  last_place;
  logic [DIGIT_W-1:0]    digit;
  logic [ROW_W-1:0]      addr_sum;

  assign advance    = !qctl.empty && (!valid_r || out_ch.ready);
  assign last_place = place_r == PLACE_W'(DIGITS - 1);
  assign pop        = advance && last_place;
  assign digit      = head_digs[PLACE_W'(DIGITS - 1) - place_r];
  assign addr_sum   = head_row + ROW_W'(acc_r);

  assign out_ch.valid        = valid_r;
  assign out_ch.base_address = addr_r;
  assign out_ch.glyph_mask   = glyph_r;
  assign out_ch.digit_value  = digit_r;
  assign out_ch.last         = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_r <= '0;
      acc_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (advance) begin
        valid_r <= 1'b1;
        if (last_place) begin
          place_r <= '0;
          acc_r   <= '0;
        end else begin
          place_r <= place_r + PLACE_W'(1);
          acc_r   <= acc_r + ACC_W'(GLYPH_STEP);
        end
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      addr_r  <= addr_sum[ADDR_OUT_W-1:0] & ADDR_MASK[ADDR_OUT_W-1:0];
      glyph_r <= ddgr_glyph(digit);
      digit_r <= digit;
      last_r  <= last_place;
    end
  end

endmodule

// File: rtl/decimal_digit_glyph_renderer_core.sv
// ============================================================================
// decimal_digit_glyph_renderer_core: 3x5 font digit renderer, top level
// Splits a 32-bit number into DIGITS decimal places and emits, per place,
// the frame-buffer address of its top-left pixel and its glyph bitmap.
// ============================================================================
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-------------------------------------------
//   in_ch   | in  | valid/ready   | value[31:0], pos_x[11:0], pos_y[11:0]
//   out_ch  | out | valid/ready   | base_address[23:0], glyph_mask[14:0],
//           |     |               | digit_value[3:0], last
//   cfg_ch  | in  | valid/ready   | frame_width[12:0], always ready
//
// One result leaves per cycle while out_ch.ready is high and the queue holds an
// item; the result port is the bottleneck.
// The front splits each item by repeated division by ten, then pushes it, and
// runs ahead of the back through a two-entry queue.
// Reset is synchronous, active low; frame_width resets to 640.
// A stalled out_ch holds its registered result; the front keeps taking
// items until the queue fills.
//
module decimal_digit_glyph_renderer_core #(
  parameter int DIGITS       = ddgr_pkg::DIGITS_DEF,
  parameter int ADDRESS_BITS = ddgr_pkg::ADDRESS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ddgr_in_if.sink     in_ch,
  ddgr_out_if.source  out_ch,
  ddgr_cfg_if.sink    cfg_ch
);
  import ddgr_pkg::*;

  // one queue entry: all digit places, least significant first, plus row base
  localparam int ENTRY_W = DIGITS * DIGIT_W + ROW_W;

  logic [FW_W-1:0]                fw_r;

  ddgr_qctl_t                     qctl;
  logic                           push;
  logic                           pop;
  logic [DIGITS-1:0][DIGIT_W-1:0] push_digs;
  logic [ROW_W-1:0]               push_row;
  logic [ENTRY_W-1:0]             head_data;
  logic [DIGITS-1:0][DIGIT_W-1:0] head_digs;
  logic [ROW_W-1:0]               head_row;

  // frame_width register, always ready: it must be written only while the block is idle (user's duty, unchecked)
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
    end else if (cfg_ch.valid) begin
      fw_r <= cfg_ch.frame_width;
    end
  end

  // front: accept, form row base, split into digits
  ddgr_front #(
    .DIGITS (DIGITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .frame_width (fw_r),
    .qctl        (qctl),
    .push        (push),
    .push_digs   (push_digs),
    .push_row    (push_row)
  );

  // queue: hold finished items between front and back
  ddgr_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_digs, push_row}),
    .pop       (pop),
    .head_data (head_data),
    .qctl      (qctl)
  );

  assign head_digs = head_data[ENTRY_W-1:ROW_W];
  assign head_row  = head_data[ROW_W-1:0];

  // back: advance one digit place per cycle while out_ch accepts and the queue holds an item, most significant first
  ddgr_back #(
    .DIGITS       (DIGITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qctl      (qctl),
    .head_digs (head_digs),
    .head_row  (head_row),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// File: verif/decimal_digit_glyph_renderer_core_tb.sv
// ============================================================================
// decimal_digit_glyph_renderer_core_tb: self-checking bench of the renderer
// Feeds numbers and positions under several frame widths, predicts the digit
// results (address, glyph, digit, last) and compares each one as it leaves.
// ============================================================================
module decimal_digit_glyph_renderer_core_tb;
  import ddgr_pkg::*;

  localparam int              PLACES      = DIGITS_DEF;
  localparam int              ADDR_BITS   = ADDRESS_BITS_DEF;
  localparam logic [FW_W-1:0] WIDTH_RESET = 13'd640;
  localparam int              DIR_ROWS    = 23;
  localparam int              PHASES      = 7;
  localparam int              PHASE_ITEMS = 22;
  // receiver holds off once, after this many results; HOLD_CYCLES sets how long
  localparam int              HOLD_AT     = 1000;
  localparam int              HOLD_CYCLES = 200;
  // cycles with no handshake on any channel before the run is called dead
  localparam int              STALL_LIMIT = 2000;

  typedef struct packed {
    logic [ADDR_OUT_W-1:0] addr;
    logic [GLYPH_W-1:0]    glyph;
    logic [DIGIT_W-1:0]    digit;
    logic                  last;
  } digit_glyph_t;

  // one row of the directed table: a register write or a number to render;
  // typed rows carry the first address and the digits as BCD nibbles
  typedef struct packed {
    logic                  is_cfg;
    logic [FW_W-1:0]       fw;
    logic [VALUE_W-1:0]    value;
    logic [POS_W-1:0]      px;
    logic [POS_W-1:0]      py;
    logic                  typed;
    logic [ADDR_OUT_W-1:0] base;
    logic [4*PLACES-1:0]   bcd;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ddgr_in_if  in_if();
  ddgr_out_if out_if();
  ddgr_cfg_if cfg_if();

  decimal_digit_glyph_renderer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  digit_glyph_t    glyphs_due[$];
  logic [FW_W-1:0] width_now;
  int unsigned     fault_cnt = 0;
  int unsigned     stall_cycles = 0;
  bit              src_burst;

  // --------------------------------------------------------------------------
  // Font: rows top to bottom, each row written column 0 first
  // --------------------------------------------------------------------------
  function automatic logic [2:0] row3(int a, int b, int c);
    return {c[0], b[0], a[0]};
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph5(logic [2:0] r0, logic [2:0] r1,
                                                logic [2:0] r2, logic [2:0] r3,
                                                logic [2:0] r4);
    return {r4, r3, r2, r1, r0};
  endfunction

  function automatic logic [GLYPH_W-1:0] digit_font(logic [DIGIT_W-1:0] d);
    case (d)
      4'd0: return glyph5(row3(1,1,1), row3(1,0,1), row3(1,0,1), row3(1,0,1), row3(1,1,1));
      4'd1: return glyph5(row3(1,1,0), row3(0,1,0), row3(0,1,0), row3(0,1,0), row3(1,1,1));
      4'd2: return glyph5(row3(1,1,1), row3(0,0,1), row3(1,1,1), row3(1,0,0), row3(1,1,1));
      4'd3: return glyph5(row3(1,1,1), row3(0,0,1), row3(1,1,1), row3(0,0,1), row3(1,1,1));
      4'd4: return glyph5(row3(1,0,1), row3(1,0,1), row3(1,1,1), row3(0,0,1), row3(0,0,1));
      4'd5: return glyph5(row3(1,1,1), row3(1,0,0), row3(1,1,1), row3(0,0,1), row3(1,1,1));
      4'd6: return glyph5(row3(1,1,1), row3(1,0,0), row3(1,1,1), row3(1,0,1), row3(1,1,1));
      4'd7: return glyph5(row3(1,1,1), row3(0,0,1), row3(0,0,1), row3(0,0,1), row3(0,0,1));
      4'd8: return glyph5(row3(1,1,1), row3(1,0,1), row3(1,1,1), row3(1,0,1), row3(1,1,1));
      4'd9: return glyph5(row3(1,1,1), row3(1,0,1), row3(1,1,1), row3(0,0,1), row3(0,0,1));
      default: return '0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Prediction: split the number into places, most significant first, and
  // step the address by five per place, wrapped to ADDR_BITS
  // --------------------------------------------------------------------------
  task automatic expect_rendering(input logic [VALUE_W-1:0] value,
                                  input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
    logic [DIGIT_W-1:0] place_digit [PLACES];
    logic [VALUE_W-1:0] rest;
    longint unsigned    row_base;
    longint unsigned    addr_mask;
    longint unsigned    addr;
    digit_glyph_t       r;
    rest      = value;
    addr_mask = (64'd1 << ADDR_BITS) - 64'd1;
    for (int p = PLACES - 1; p >= 0; p--) begin
      place_digit[p] = DIGIT_W'(rest % 32'd10);
      rest           = rest / 32'd10;
    end
    row_base = longint'(py) * longint'(width_now) + longint'(px);
    for (int p = 0; p < PLACES; p++) begin
      addr    = (row_base + 64'd5 * p) & addr_mask;
      r.addr  = addr[ADDR_OUT_W-1:0];
      r.digit = place_digit[p];
      r.glyph = digit_font(place_digit[p]);
      r.last  = (p == PLACES - 1);
      glyphs_due.push_back(r);
    end
  endtask

  // expectation straight from a table row: first address plus BCD digits
  task automatic expect_typed(input logic [ADDR_OUT_W-1:0] base,
                              input logic [4*PLACES-1:0] bcd);
    digit_glyph_t r;
    for (int p = 0; p < PLACES; p++) begin
      r.addr  = base + ADDR_OUT_W'(5 * p);
      r.digit = bcd[4*(PLACES-1-p) +: 4];
      r.glyph = digit_font(r.digit);
      r.last  = (p == PLACES - 1);
      glyphs_due.push_back(r);
    end
  endtask

  function automatic void note_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%s", msg);
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  function automatic stim_row_t cfg_row(logic [FW_W-1:0] fw);
    stim_row_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.fw     = fw;
    return s;
  endfunction

  function automatic stim_row_t num_row(logic [VALUE_W-1:0] value, logic [POS_W-1:0] px,
                                        logic [POS_W-1:0] py, int typed,
                                        logic [ADDR_OUT_W-1:0] base,
                                        logic [4*PLACES-1:0] bcd);
    stim_row_t s;
    s       = '0;
    s.value = value;
    s.px    = px;
    s.py    = py;
    s.typed = (typed != 0);
    s.base  = base;
    s.bcd   = bcd;
    return s;
  endfunction

  function automatic stim_row_t stim_row(int i);
    case (i)
      // reset width 640: zero, all ones at the far corner, one leading digit
      0:  return num_row(32'd0,          12'd0,    12'd0,    1, 24'd0,       60'h0);
      1:  return num_row(32'hFFFF_FFFF,  12'd4095, 12'd4095, 1, 24'd2624895, 60'h000004294967295);
      2:  return num_row(32'd1000000000, 12'd0,    12'd1,    1, 24'd640,     60'h000001000000000);
      3:  return num_row(32'd9,          12'd4095, 12'd0,    1, 24'd4095,    60'h9);
      4:  return num_row(32'd1234567890, 12'd7,    12'd3,    0, '0, '0);
      5:  return num_row(32'd3141592653, 12'd2000, 12'd1000, 0, '0, '0);
      // zero width: every row lands on the same address
      6:  return cfg_row(13'd0);
      7:  return num_row(32'd5,          12'd100,  12'd4095, 1, 24'd100,     60'h5);
      8:  return num_row(32'd987654321,  12'd0,    12'd123,  1, 24'd0,       60'h000000987654321);
      9:  return num_row(32'hFFFF_FFFF,  12'd4095, 12'd4095, 1, 24'd4095,    60'h000004294967295);
      10: return cfg_row(13'd1);
      11: return num_row(32'd0,          12'd4095, 12'd4095, 1, 24'd8190,    60'h0);
      12: return num_row(32'd2718281828, 12'd17,   12'd2048, 0, '0, '0);
      // width 4096: the far corner sits at the top of the address space
      13: return cfg_row(13'd4096);
      14: return num_row(32'd0,          12'd4095, 12'd4095, 1, 24'hFF_FFFF,  60'h0);
      15: return num_row(32'd1,          12'd0,    12'd4095, 1, 24'hFF_F000,  60'h1);
      16: return num_row(32'd999999999,  12'd4000, 12'd4094, 0, '0, '0);
      // widest register value, above the nominal range; addresses wrap
      17: return cfg_row(13'd8191);
      18: return num_row(32'hAAAA_AAAA,  12'd4095, 12'd4095, 0, '0, '0);
      19: return num_row(32'h5555_5555,  12'd2730, 12'd1365, 0, '0, '0);
      20: return num_row(32'd10,         12'd0,    12'd0,    1, 24'd0,       60'h10);
      21: return num_row(32'd100,        12'd1,    12'd2048, 0, '0, '0);
      default: return cfg_row(WIDTH_RESET);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus shapes
  // --------------------------------------------------------------------------
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] p10;
    int                 k;
    p10 = 32'd1;
    k   = $urandom_range(0, 9);
    for (int j = 0; j < k; j++) p10 = p10 * 32'd10;
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 99);
      1:       return p10;
      2:       return (k == 0) ? 32'hFFFF_FFFF : p10 - 32'd1;
      3:       return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [FW_W-1:0] phase_width(int ph);
    case (ph)
      0:       return FW_W'($urandom_range(1, 4096));
      1:       return 13'd8191;
      2:       return 13'd0;
      3:       return 13'd4096;
      4:       return 13'd1;
      5:       return FW_W'($urandom_range(0, 8191));
      default: return WIDTH_RESET;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // offer one number after a random gap, or none in a burst; predict once it is taken
  task automatic send_number(input logic [VALUE_W-1:0] value, input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] py, input logic typed,
                             input logic [ADDR_OUT_W-1:0] base,
                             input logic [4*PLACES-1:0] bcd);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    in_if.pos_x <= px;
    in_if.pos_y <= py;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (typed) expect_typed(base, bcd);
    else expect_rendering(value, px, py);
  endtask

  // drop valid and hold until every predicted result has been taken
  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (glyphs_due.size() != 0) @(posedge clk);
  endtask

  // write the stride only with nothing in flight
  task automatic write_frame_width(input logic [FW_W-1:0] fw);
    drain_results();
    @(negedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.frame_width <= fw;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    width_now = fw;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    stim_row_t row;
    in_if.valid        = 1'b0;
    in_if.value        = '0;
    in_if.pos_x        = '0;
    in_if.pos_y        = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.frame_width = '0;
    rst_n              = 1'b0;
    width_now          = WIDTH_RESET;
    src_burst          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: extremes, wrap, zero and oversize widths
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = stim_row(i);
      if (row.is_cfg) write_frame_width(row.fw);
      else send_number(row.value, row.px, row.py, row.typed, row.base, row.bcd);
    end

    // random part: one width per phase, every third phase back to back
    for (int ph = 0; ph < PHASES; ph++) begin
      write_frame_width(phase_width(ph));
      src_burst = (ph % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // pause once mid-phase until the block has emptied
        if (ph == 3 && n == PHASE_ITEMS / 2) drain_results();
        send_number(pick_value(), pick_pos(), pick_pos(), 1'b0, '0, '0);
      end
    end

    drain_results();
    // catch any result beyond the last expected one
    repeat (40) @(posedge clk);
    if (fault_cnt == 0 && glyphs_due.size() == 0) begin
      $display("decimal_digit_glyph_renderer_core_tb: done, clean");
    end else begin
      $display("decimal_digit_glyph_renderer_core_tb: done, errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side: random stalls, stall-free stretches, one long hold-off, compare each result
  // --------------------------------------------------------------------------
  initial begin : result_sink
    digit_glyph_t got;
    digit_glyph_t want;
    int           hold;
    int unsigned  seen;
    out_if.ready = 1'b0;
    seen         = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (seen == HOLD_AT) hold = HOLD_CYCLES;
      else if ((seen / 150) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, 9);
      @(negedge clk);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.addr  = out_if.base_address;
      got.glyph = out_if.glyph_mask;
      got.digit = out_if.digit_value;
      got.last  = out_if.last;
      seen++;
      if (glyphs_due.size() == 0) begin
        note_fault($sformatf("result %0d unexpected: addr=%h glyph=%h digit=%0d last=%b",
                             seen, got.addr, got.glyph, got.digit, got.last));
      end else begin
        want = glyphs_due.pop_front();
        if (got.addr !== want.addr || got.glyph !== want.glyph ||
            got.digit !== want.digit || got.last !== want.last) begin
          note_fault($sformatf(
            "result %0d: expected addr=%h glyph=%h digit=%0d last=%b, got addr=%h glyph=%h digit=%0d last=%b",
            seen, want.addr, want.glyph, want.digit, want.last,
            got.addr, got.glyph, got.digit, got.last));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles with no handshake anywhere
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("decimal_digit_glyph_renderer_core_tb: done, errors");
      $finish;
    end
  end

endmodule
